// ===== rtl/assert_macros.svh =====
// Assertion helpers used by wdt_core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that an expression holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Check that a condition implies a consequence in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) else $error(msg);

// Check that a condition implies a consequence in the next cycle.
`define ASSERT_NEXT(label, clk, rst, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) else $error(msg);

`endif

// ===== rtl/wdt_pkg.sv =====
package wdt_pkg;

  typedef enum logic [2:0] {
    CMD_TICK      = 3'd0,
    CMD_WR_PASS   = 3'd1,
    CMD_WR_VALUE  = 3'd2,
    CMD_RD_CTRL   = 3'd3,
    CMD_RD_COUNT  = 3'd4,
    CMD_IRQ_CHECK = 3'd5
  } cmd_t;

  typedef enum logic [1:0] {
    IRQ_NONE     = 2'd0,
    IRQ_RESET    = 2'd1,
    IRQ_INTERVAL = 2'd2
  } irq_t;

  // Field packing: read_data in the lowest bits, then irq_kind, then overflow_flag.
  typedef struct packed {
    logic       overflow_flag;
    irq_t       irq_kind;
    logic [7:0] read_data;
  } result_t;

  localparam int unsigned RESULT_W = $bits(result_t);
  localparam int unsigned OUT_TDATA_W = 16;

  localparam logic [9:0]  HOLD_TICKS  = 10'd518;
  localparam logic [7:0]  PW_CTRL     = 8'hA5;
  localparam logic [7:0]  PW_COUNT    = 8'h5A;
  localparam logic [7:0]  CTRL_RESET  = 8'h10;
  localparam logic [7:0]  CTRL_ONE    = 8'h10;
  localparam logic [7:0]  CTRL_NO_OVF = 8'h7F;
  localparam logic [7:0]  CTRL_OVF    = 8'h80;

  // Control register bit positions
  localparam int unsigned BIT_OVF  = 7;
  localparam int unsigned BIT_WDT  = 6;
  localparam int unsigned BIT_EN   = 5;
  localparam int unsigned BIT_ONE  = 4;
  localparam int unsigned BIT_RSEL = 3;

  localparam logic [3:0] STEP_SHIFT [8] = '{4'd1, 4'd5, 4'd6, 4'd7, 4'd8, 4'd9, 4'd11, 4'd12};

  // Prescaler period for a clock select code: 2^k ticks
  function automatic logic [12:0] step_limit(input logic [2:0] sel);
    step_limit = 13'd1 << STEP_SHIFT[sel];
  endfunction

endpackage

// ===== rtl/wdt_core.sv =====
`include "assert_macros.svh"

module wdt_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              step_en,
  input  wdt_pkg::cmd_t     command,
  input  logic [7:0]        data,
  output wdt_pkg::result_t  result
);

  logic [7:0]  ctrl, ctrl_next;
  logic        seen, seen_next;
  logic [7:0]  counter, counter_next;
  logic [7:0]  pass, pass_next;
  logic [11:0] prescaler, prescaler_next;
  logic [9:0]  hold, hold_next;
  logic [12:0] pre_inc;
  logic [7:0]  ctrl_wr;

  assign pre_inc = {1'b0, prescaler} + 13'd1;

  always_comb begin
    ctrl_wr = data | wdt_pkg::CTRL_ONE;
    if (!seen) begin
      ctrl_wr = ctrl_wr | wdt_pkg::CTRL_OVF;
    end
    // flag can only stay or clear through a write, never set
    ctrl_wr = ctrl_wr & (wdt_pkg::CTRL_NO_OVF | ctrl);
  end

  always_comb begin
    ctrl_next      = ctrl;
    seen_next      = seen;
    counter_next   = counter;
    pass_next      = pass;
    prescaler_next = prescaler;
    hold_next      = hold;
    result         = '0;
    case (command)
      wdt_pkg::CMD_TICK: begin
        if (ctrl[wdt_pkg::BIT_EN]) begin
          if (hold != 10'd0) begin
            hold_next = hold - 10'd1;
          end else if (pre_inc < wdt_pkg::step_limit(ctrl[2:0])) begin
            prescaler_next = pre_inc[11:0];
          end else begin
            prescaler_next = '0;
            if (counter == 8'hFF) begin
              ctrl_next[wdt_pkg::BIT_OVF] = 1'b1;
              counter_next = '0;
              if (ctrl[wdt_pkg::BIT_WDT]) begin
                hold_next = wdt_pkg::HOLD_TICKS;
              end
            end else begin
              counter_next = counter + 8'd1;
            end
          end
        end
      end
      wdt_pkg::CMD_WR_PASS: begin
        pass_next = data;
      end
      wdt_pkg::CMD_WR_VALUE: begin
        if (pass == wdt_pkg::PW_CTRL) begin
          ctrl_next      = ctrl_wr;
          prescaler_next = '0;
          hold_next      = '0;
          pass_next      = '0;
        end else if (pass == wdt_pkg::PW_COUNT) begin
          counter_next   = data;
          prescaler_next = '0;
          hold_next      = '0;
          pass_next      = '0;
        end
      end
      wdt_pkg::CMD_RD_CTRL: begin
        result.read_data = ctrl;
        seen_next        = ctrl[wdt_pkg::BIT_OVF];
      end
      wdt_pkg::CMD_RD_COUNT: begin
        result.read_data = counter;
      end
      wdt_pkg::CMD_IRQ_CHECK: begin
        if (ctrl[wdt_pkg::BIT_OVF]) begin
          ctrl_next[wdt_pkg::BIT_OVF] = 1'b0;
          result.irq_kind = ctrl[wdt_pkg::BIT_RSEL] ? wdt_pkg::IRQ_RESET
                                                    : wdt_pkg::IRQ_INTERVAL;
        end
      end
      default: begin
      end
    endcase
    result.overflow_flag = ctrl_next[wdt_pkg::BIT_OVF];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl      <= wdt_pkg::CTRL_RESET;
      seen      <= 1'b0;
      counter   <= '0;
      pass      <= '0;
      prescaler <= '0;
      hold      <= '0;
    end else if (step_en) begin
      ctrl      <= ctrl_next;
      seen      <= seen_next;
      counter   <= counter_next;
      pass      <= pass_next;
      prescaler <= prescaler_next;
      hold      <= hold_next;
    end
  end

  `ASSERT_ALWAYS(a_ctrl_one, clk, rst, ctrl[wdt_pkg::BIT_ONE], "control bit 4 cleared")
  `ASSERT_ALWAYS(a_hold_range, clk, rst, hold <= wdt_pkg::HOLD_TICKS, "hold count out of range")
  `ASSERT_IMPLIES(a_irq_ack, clk, rst, result.irq_kind != wdt_pkg::IRQ_NONE,
    !result.overflow_flag && command == wdt_pkg::CMD_IRQ_CHECK, "interrupt not acknowledged")
  `ASSERT_NEXT(a_prescaler_hold, clk, rst, step_en && hold != 10'd0,
    $stable(prescaler), "prescaler moved during hold")

endmodule

// ===== rtl/wdt_out_stage.sv =====
module wdt_out_stage (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  wdt_pkg::result_t result,
  input  logic             tready,
  output logic             tvalid,
  output logic             free,
  output logic [wdt_pkg::OUT_TDATA_W-1:0] tdata
);

  wdt_pkg::result_t held;

  assign free   = !tvalid || tready;
  assign tdata  = {{(wdt_pkg::OUT_TDATA_W - wdt_pkg::RESULT_W){1'b0}}, held};

  always_ff @(posedge clk) begin
    if (rst) begin
      tvalid <= 1'b0;
    end else if (free) begin
      tvalid <= load;
    end
  end

  // hold payload while the receiver stalls
  always_ff @(posedge clk) begin
    if (load && free) begin
      held <= result;
    end
  end

endmodule

// ===== rtl/watchdog_timer_registers.sv =====
// Password-protected 8-bit watchdog / interval timer with its register interface.
// Input channel s_*: one transfer per item; s_tuser carries the command
// (tick, password write, value write, control read, counter read, interrupt
// check) and s_tdata the write byte.
// Output channel m_*: exactly one transfer per input item, in order; m_tdata
// carries read_data, irq_kind and overflow_flag.
// The result is registered and appears on m_* in the cycle after the input transfer.
// Throughput: one item per cycle unless the receiver stalls; all timer state updates
// in the cycle of the input transfer and the result lands in a single output register.
// When the receiver stalls, the output register holds its result and s_tready
// drops until that result is taken; the input is refused only while the
// output register is full and m_tready is low.
// Reset: control register 0x10, counter, prescaler, hold count, password latch
// and read-seen flag cleared; no result pending.
module watchdog_timer_registers (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data
  input  logic [2:0]  s_tuser,   // [2:0] command
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata    // [7:0] read_data, [9:8] irq_kind, [10] overflow_flag
);

  logic             step_en;
  logic             out_free;
  wdt_pkg::result_t result;

  assign s_tready = out_free;
  assign step_en  = s_tvalid && out_free;

  wdt_core u_core (
    .clk     (clk),
    .rst     (rst),
    .step_en (step_en),
    .command (wdt_pkg::cmd_t'(s_tuser)),
    .data    (s_tdata),
    .result  (result)
  );

  wdt_out_stage u_out (
    .clk    (clk),
    .rst    (rst),
    .load   (step_en),
    .result (result),
    .tready (m_tready),
    .tvalid (m_tvalid),
    .free   (out_free),
    .tdata  (m_tdata)
  );

endmodule

// ===== dv/watchdog_timer_registers_checker.sv =====
`timescale 1ns / 100ps
module watchdog_timer_registers_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data
  input  logic [2:0]  s_tuser,   // [2:0] command
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [15:0] m_tdata,   // [7:0] read_data, [9:8] irq_kind, [10] overflow_flag
  output int          mismatches,
  output int          outstanding
);

  // Shadow copy of the timer state
  logic [7:0]  ctrl_q;
  logic [7:0]  count_q;
  logic [7:0]  latch_q;
  logic        seen_q;
  logic [11:0] presc_q;
  logic [9:0]  hold_q;

  wdt_pkg::result_t predicted_outputs[$];

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t: %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    mismatches++;
  endtask

  task automatic timer_tick();
    logic [12:0] period;
    if (!ctrl_q[wdt_pkg::BIT_EN]) return;
    if (hold_q != '0) begin
      hold_q = hold_q - 10'd1;
      return;
    end
    period = 13'd1 << wdt_pkg::STEP_SHIFT[ctrl_q[2:0]];
    if ({1'b0, presc_q} + 13'd1 < period) begin
      presc_q = presc_q + 12'd1;
      return;
    end
    presc_q = '0;
    if (count_q == 8'hFF) begin
      ctrl_q[wdt_pkg::BIT_OVF] = 1'b1;
      count_q = '0;
      if (ctrl_q[wdt_pkg::BIT_WDT]) hold_q = wdt_pkg::HOLD_TICKS;
    end else begin
      count_q = count_q + 8'd1;
    end
  endtask

  task automatic apply_access(input logic [2:0] code, input logic [7:0] value,
                              output wdt_pkg::result_t res);
    logic [7:0] next_ctrl;
    logic       unlocked;
    res = '0;
    case (code)
      wdt_pkg::CMD_TICK: timer_tick();
      wdt_pkg::CMD_WR_PASS: latch_q = value;
      wdt_pkg::CMD_WR_VALUE: begin
        unlocked = 1'b1;
        if (latch_q == wdt_pkg::PW_CTRL) begin
          // flag can only drop after a control read that saw it set
          next_ctrl = value | wdt_pkg::CTRL_ONE;
          if (!seen_q) next_ctrl = next_ctrl | wdt_pkg::CTRL_OVF;
          ctrl_q = next_ctrl & (wdt_pkg::CTRL_NO_OVF | ctrl_q);
        end else if (latch_q == wdt_pkg::PW_COUNT) begin
          count_q = value;
        end else begin
          unlocked = 1'b0;
        end
        if (unlocked) begin
          presc_q = '0;
          hold_q  = '0;
          latch_q = '0;
        end
      end
      wdt_pkg::CMD_RD_CTRL: begin
        res.read_data = ctrl_q;
        seen_q = ctrl_q[wdt_pkg::BIT_OVF];
      end
      wdt_pkg::CMD_RD_COUNT: res.read_data = count_q;
      wdt_pkg::CMD_IRQ_CHECK: begin
        if (ctrl_q[wdt_pkg::BIT_OVF]) begin
          ctrl_q[wdt_pkg::BIT_OVF] = 1'b0;
          res.irq_kind = ctrl_q[wdt_pkg::BIT_RSEL] ? wdt_pkg::IRQ_RESET
                                                   : wdt_pkg::IRQ_INTERVAL;
        end
      end
      default: ;
    endcase
    res.overflow_flag = ctrl_q[wdt_pkg::BIT_OVF];
  endtask

  always @(posedge clk) begin : monitor
    wdt_pkg::result_t got;
    wdt_pkg::result_t want;
    wdt_pkg::result_t fresh;
    if (rst) begin
      ctrl_q  = wdt_pkg::CTRL_RESET;
      count_q = '0;
      latch_q = '0;
      seen_q  = 1'b0;
      presc_q = '0;
      hold_q  = '0;
      predicted_outputs.delete();
    end else begin
      // retire the older result before predicting the new item
      if (m_tvalid && m_tready) begin
        got = wdt_pkg::result_t'(m_tdata[wdt_pkg::RESULT_W-1:0]);
        if (predicted_outputs.size() == 0) begin
          report_mismatch("result transfer with no prediction pending", m_tdata, 0);
        end else begin
          want = predicted_outputs.pop_front();
          if (got.read_data != want.read_data)
            report_mismatch("read_data", got.read_data, want.read_data);
          if (got.irq_kind != want.irq_kind)
            report_mismatch("irq_kind", got.irq_kind, want.irq_kind);
          if (got.overflow_flag != want.overflow_flag)
            report_mismatch("overflow_flag", got.overflow_flag, want.overflow_flag);
          if (m_tdata[15:wdt_pkg::RESULT_W] != '0)
            report_mismatch("tdata padding", m_tdata[15:wdt_pkg::RESULT_W], 0);
        end
      end
      if (s_tvalid && s_tready) begin
        apply_access(s_tuser, s_tdata, fresh);
        predicted_outputs.push_back(fresh);
      end
    end
    outstanding <= predicted_outputs.size();
  end

endmodule

// ===== dv/watchdog_timer_registers_tb.sv =====
`timescale 1ns / 100ps
module watchdog_timer_registers_tb;

  localparam int ITEM_TARGET = 950;

  typedef enum logic [1:0] {
    RX_OPEN    = 2'd0,
    RX_CHOPPY  = 2'd1,
    RX_CLOGGED = 2'd2
  } rx_mode_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;
  logic [2:0]  s_tuser = wdt_pkg::CMD_TICK;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;

  int mismatches;
  int outstanding;
  int items_sent = 0;
  int burst_left = 0;

  rx_mode_t rx_mode = RX_OPEN;
  int       rx_phase_left = 0;

  always #5 clk = ~clk;

  watchdog_timer_registers dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  watchdog_timer_registers_checker result_check (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  // Receiver: phases of open, choppy or mostly blocked acceptance
  always @(posedge clk) begin
    if (rx_phase_left == 0) begin
      rx_mode       <= rx_mode_t'($urandom_range(0, 2));
      rx_phase_left <= $urandom_range(4, 60);
      m_tready      <= 1'b1;
    end else begin
      rx_phase_left <= rx_phase_left - 1;
      case (rx_mode)
        RX_OPEN:    m_tready <= 1'b1;
        RX_CHOPPY:  m_tready <= ($urandom_range(0, 3) != 0);
        default:    m_tready <= ($urandom_range(0, 4) == 0);
      endcase
    end
  end

  // Drive one item and hold it until the transfer happens
  task automatic send_item(input wdt_pkg::cmd_t code, input logic [7:0] value);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 6);
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 200)
                                               : $urandom_range(1, 30);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= code;
    s_tdata  <= value;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    burst_left--;
    items_sent++;
  endtask

  // Control byte biased toward an enabled timer with a fast prescaler
  function automatic logic [7:0] make_ctrl_byte();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    b[2:0] = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(0, 7))
                                         : 3'($urandom_range(0, 1));
    b[wdt_pkg::BIT_EN]  = ($urandom_range(0, 7) != 0);
    b[wdt_pkg::BIT_WDT] = ($urandom_range(0, 3) == 0);
    return b;
  endfunction

  task automatic run_random_sequence();
    int pick;
    int len;
    pick = $urandom_range(0, 99);
    if (pick < 18) begin
      send_item(wdt_pkg::CMD_WR_PASS, wdt_pkg::PW_CTRL);
      // accesses that leave the latch alone may sit between password and write
      if ($urandom_range(0, 3) == 0)
        send_item($urandom_range(0, 1) ? wdt_pkg::CMD_TICK : wdt_pkg::CMD_RD_COUNT,
                  8'($urandom()));
      send_item(wdt_pkg::CMD_WR_VALUE, make_ctrl_byte());
    end else if (pick < 34) begin
      send_item(wdt_pkg::CMD_WR_PASS, wdt_pkg::PW_COUNT);
      if ($urandom_range(0, 3) != 0)
        send_item(wdt_pkg::CMD_WR_VALUE, 8'($urandom_range(8'hF0, 8'hFF)));
      else
        send_item(wdt_pkg::CMD_WR_VALUE, 8'($urandom()));
    end else if (pick < 60) begin
      // a rare long run lets a watchdog hold expire
      len = ($urandom_range(0, 49) == 0) ? $urandom_range(300, 560)
                                         : $urandom_range(1, 24);
      repeat (len) send_item(wdt_pkg::CMD_TICK, 8'($urandom()));
    end else if (pick < 70) begin
      send_item(wdt_pkg::CMD_RD_CTRL, 8'($urandom()));
      if ($urandom_range(0, 1)) begin
        send_item(wdt_pkg::CMD_WR_PASS, wdt_pkg::PW_CTRL);
        send_item(wdt_pkg::CMD_WR_VALUE, make_ctrl_byte() & wdt_pkg::CTRL_NO_OVF);
      end
    end else if (pick < 82) begin
      send_item($urandom_range(0, 1) ? wdt_pkg::CMD_IRQ_CHECK : wdt_pkg::CMD_RD_COUNT,
                8'($urandom()));
    end else if (pick < 92) begin
      send_item(wdt_pkg::CMD_WR_PASS, 8'($urandom()));
      send_item(wdt_pkg::CMD_WR_VALUE, 8'($urandom()));
    end else begin
      send_item(wdt_pkg::cmd_t'($urandom_range(0, 5)), 8'($urandom()));
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // reset values, locked write, disabled timer
    send_item(wdt_pkg::CMD_RD_CTRL, 8'hFF);
    send_item(wdt_pkg::CMD_RD_COUNT, 8'h00);
    send_item(wdt_pkg::CMD_IRQ_CHECK, 8'hFF);
    send_item(wdt_pkg::CMD_WR_VALUE, 8'hFF);
    send_item(wdt_pkg::CMD_TICK, 8'h00);
    // password survives a read; enable with reset select, fastest prescaler
    send_item(wdt_pkg::CMD_WR_PASS, wdt_pkg::PW_CTRL);
    send_item(wdt_pkg::CMD_RD_COUNT, 8'h00);
    send_item(wdt_pkg::CMD_WR_VALUE, 8'h28);
    send_item(wdt_pkg::CMD_WR_PASS, wdt_pkg::PW_COUNT);
    send_item(wdt_pkg::CMD_WR_VALUE, 8'hFF);
    send_item(wdt_pkg::CMD_TICK, 8'hFF);
    send_item(wdt_pkg::CMD_TICK, 8'h00);
    send_item(wdt_pkg::CMD_RD_CTRL, 8'h00);
    send_item(wdt_pkg::CMD_IRQ_CHECK, 8'h00);
    // overflow again, then clear the flag on a stale read of it
    send_item(wdt_pkg::CMD_WR_PASS, wdt_pkg::PW_COUNT);
    send_item(wdt_pkg::CMD_WR_VALUE, 8'hFF);
    send_item(wdt_pkg::CMD_TICK, 8'h00);
    send_item(wdt_pkg::CMD_TICK, 8'h00);
    send_item(wdt_pkg::CMD_WR_PASS, wdt_pkg::PW_CTRL);
    send_item(wdt_pkg::CMD_WR_VALUE, 8'h6F);
    send_item(wdt_pkg::CMD_RD_CTRL, 8'h00);
    // watchdog overflow starts the hold; interval interrupt
    send_item(wdt_pkg::CMD_WR_PASS, wdt_pkg::PW_CTRL);
    send_item(wdt_pkg::CMD_WR_VALUE, 8'h60);
    send_item(wdt_pkg::CMD_WR_PASS, wdt_pkg::PW_COUNT);
    send_item(wdt_pkg::CMD_WR_VALUE, 8'hFF);
    send_item(wdt_pkg::CMD_TICK, 8'h00);
    send_item(wdt_pkg::CMD_TICK, 8'h00);
    send_item(wdt_pkg::CMD_TICK, 8'h00);
    send_item(wdt_pkg::CMD_RD_COUNT, 8'h00);
    send_item(wdt_pkg::CMD_IRQ_CHECK, 8'h00);

    while (items_sent < ITEM_TARGET) run_random_sequence();
    s_tvalid <= 1'b0;

    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

  initial begin
    #5000000;
    $display("FAIL");
    $finish;
  end

endmodule

// ===== watchdog_timer_registers.f =====
+incdir+rtl
rtl/wdt_pkg.sv
rtl/wdt_core.sv
rtl/wdt_out_stage.sv
rtl/watchdog_timer_registers.sv
dv/watchdog_timer_registers_checker.sv
dv/watchdog_timer_registers_tb.sv
